[sv/pid_db_pkg.sv]
// ----------------------------------------------------------------------------
// pid_db_pkg: shared types and constants of the deadband PID controller
// Field widths, register indexes, reset values and the error stage bundle.
// ----------------------------------------------------------------------------
package pid_db_pkg;

  localparam int ERR_W   = 16;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int ESUM_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 15;
  localparam int DRIVE_W = 32;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;

  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + ESUM_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int FRAC_W   = 8;

  localparam logic [DB_W-1:0] DEADBAND_RESET = 15'd154;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_DEADBAND        = 3'd3,
    REG_DEADBAND_ENABLE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [ESUM_W-1:0] esum;
    logic signed [DIFF_W-1:0] diff;
  } err_stage_t;

endpackage

[sv/pid_db_err.sv]
// ----------------------------------------------------------------------------
// pid_db_err: error front end
// Saturated error, deadband, saturating integral and error difference.
// ----------------------------------------------------------------------------
module pid_db_err (
  input  logic signed [pid_db_pkg::ERR_W-1:0]  target,
  input  logic signed [pid_db_pkg::ERR_W-1:0]  feedback,
  input  logic        [pid_db_pkg::DB_W-1:0]   deadband,
  input  logic                                 deadband_enable,
  input  logic signed [pid_db_pkg::ESUM_W-1:0] error_sum,
  input  logic signed [pid_db_pkg::ERR_W-1:0]  previous_error,
  output pid_db_pkg::err_stage_t               res
);

  localparam int EW = pid_db_pkg::ERR_W;
  localparam int SW = pid_db_pkg::ESUM_W;

  logic signed [EW:0]   raw;
  logic signed [EW-1:0] sat;
  logic        [EW:0]   mag;
  logic signed [EW-1:0] err;
  logic signed [SW:0]   sum_raw;
  logic signed [SW-1:0] sum_sat;

  always_comb begin
    raw = {target[EW-1], target} - {feedback[EW-1], feedback};
    if (raw[EW] != raw[EW-1]) begin
      sat = raw[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end else begin
      sat = raw[EW-1:0];
    end

    mag = sat[EW-1] ? ((EW+1)'(0) - {sat[EW-1], sat}) : {1'b0, sat};

    if (deadband_enable && (mag < {{(EW+1-pid_db_pkg::DB_W){1'b0}}, deadband})) begin
      err = '0;
    end else begin
      err = sat;
    end

    sum_raw = {error_sum[SW-1], error_sum} + {{(SW+1-EW){err[EW-1]}}, err};
    if (sum_raw[SW] != sum_raw[SW-1]) begin
      sum_sat = sum_raw[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_raw[SW-1:0];
    end

    res.err  = err;
    res.esum = sum_sat;
    res.diff = {err[EW-1], err} - {previous_error[EW-1], previous_error};
  end

endmodule

[sv/pid_controller_with_deadband_top.sv]
// ----------------------------------------------------------------------------
// pid_controller_with_deadband_top: positional PID loop with deadband
// Error stage, product stage and saturating output register.
// ----------------------------------------------------------------------------
// At accept the integral and last error update and the error stage loads; the
// item then passes the product and output registers. Throughput: one item per
// cycle unless stalled; a stage holds only while the next is full and stalled.
// Reset: gains 0, deadband 154, deadband enabled, integral and last error 0,
// pipeline empty.
module pid_controller_with_deadband_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [pid_db_pkg::IDX_W-1:0]     cfg_index,
  input  logic        [pid_db_pkg::CFG_W-1:0]     cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [pid_db_pkg::ERR_W-1:0]     target,
  input  logic signed [pid_db_pkg::ERR_W-1:0]     feedback,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pid_db_pkg::DRIVE_W-1:0]   drive
);

  localparam int AW = pid_db_pkg::ACC_W;
  localparam int PW = pid_db_pkg::PROD_P_W;
  localparam int IW = pid_db_pkg::PROD_I_W;
  localparam int DW = pid_db_pkg::PROD_D_W;
  localparam int OW = pid_db_pkg::DRIVE_W;
  localparam int QW = AW - pid_db_pkg::FRAC_W;

  logic signed [pid_db_pkg::GAIN_W-1:0] gain_p;
  logic signed [pid_db_pkg::GAIN_W-1:0] gain_i;
  logic signed [pid_db_pkg::GAIN_W-1:0] gain_d;
  logic        [pid_db_pkg::DB_W-1:0]   deadband;
  logic                                 deadband_enable;

  logic signed [pid_db_pkg::ESUM_W-1:0] error_sum;
  logic signed [pid_db_pkg::ERR_W-1:0]  previous_error;

  pid_db_pkg::err_stage_t front;
  pid_db_pkg::err_stage_t s1;
  logic                   s1_valid;
  logic                   s1_ready;

  logic signed [PW-1:0] prod_p;
  logic signed [IW-1:0] prod_i;
  logic signed [DW-1:0] prod_d;
  logic                 s2_valid;
  logic                 s2_ready;
  logic                 out_free;

  logic signed [AW-1:0] acc;
  logic signed [QW-1:0] quot;
  logic signed [OW-1:0] drive_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      deadband        <= pid_db_pkg::DEADBAND_RESET;
      deadband_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pid_db_pkg::REG_GAIN_P:          gain_p <= cfg_data;
        pid_db_pkg::REG_GAIN_I:          gain_i <= cfg_data;
        pid_db_pkg::REG_GAIN_D:          gain_d <= cfg_data;
        pid_db_pkg::REG_DEADBAND:        deadband <= cfg_data[pid_db_pkg::DB_W-1:0];
        pid_db_pkg::REG_DEADBAND_ENABLE: deadband_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pid_db_err u_err (
    .target          (target),
    .feedback        (feedback),
    .deadband        (deadband),
    .deadband_enable (deadband_enable),
    .error_sum       (error_sum),
    .previous_error  (previous_error),
    .res             (front)
  );

  assign out_free = !out_valid || out_ready;
  assign s2_ready = !s2_valid || out_free;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Error stage: advance loop state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
      if (in_valid) begin
        error_sum      <= front.esum;
        previous_error <= front.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1 <= front;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      prod_p <= gain_p * $signed(s1.err);
      prod_i <= gain_i * $signed(s1.esum);
      prod_d <= gain_d * $signed(s1.diff);
    end
  end

  // Sum, floor scale and saturate
  always_comb begin
    acc = {{(AW-PW){prod_p[PW-1]}}, prod_p}
        + {{(AW-IW){prod_i[IW-1]}}, prod_i}
        + {{(AW-DW){prod_d[DW-1]}}, prod_d};
    quot = acc[AW-1:pid_db_pkg::FRAC_W];
    if (quot[QW-1:OW-1] == {(QW-OW+1){quot[QW-1]}}) begin
      drive_next = quot[OW-1:0];
    end else begin
      drive_next = quot[QW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_free) begin
      drive <= drive_next;
    end
  end

endmodule

[tb/sv/tb_pid_controller_with_deadband_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_with_deadband_top: self-checking bench of the deadband PID
// A directed table covers reset values, error and deadband edges, disabled
// deadband and unmapped register writes. Constant full-scale error sweeps wind
// the integral far in both directions and back. Random phases then reprogram
// every register and stream random items. Both handshakes idle at random.
// Every drive is checked against a table value or a cycle-free PID predictor.
// ----------------------------------------------------------------------------
module tb_pid_controller_with_deadband_top;

  localparam int          IDX_W           = pid_db_pkg::IDX_W;
  localparam int          CFG_W           = pid_db_pkg::CFG_W;
  localparam int          ERR_W           = pid_db_pkg::ERR_W;
  localparam int          GAIN_W          = pid_db_pkg::GAIN_W;
  localparam int          DB_W            = pid_db_pkg::DB_W;
  localparam int          DRIVE_W         = pid_db_pkg::DRIVE_W;
  localparam int          FRAC_W          = pid_db_pkg::FRAC_W;

  localparam int          CYCLE_LIMIT     = 2_000_000;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 80;
  localparam int          HOLD_PHASE      = 2;
  localparam int          RANDOM_PHASES   = 6;
  localparam int          PHASE_ITEMS     = 56;
  localparam int          WINDUP_ITEMS    = 48;
  localparam int          RECENTER_ITEMS  = 48;
  localparam int          REPORT_CAP      = 200;
  localparam int          N_DIRECTED      = 34;
  localparam longint      ERR_HI          = 64'sd32767;
  localparam longint      ERR_LO          = -64'sd32768;
  localparam longint      SUM_HI          = 64'sd2147483647;
  localparam longint      SUM_LO          = -64'sd2147483648;
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {ROW_REG, ROW_ITEM, ROW_CHECKED} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_TOGGLE} stall_mode_t;
  typedef enum logic [1:0] {ITEM_ANY, ITEM_EDGE, ITEM_EXTREME, ITEM_NEAR} item_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [15:0]              a;
    logic [15:0]              b;
    logic signed [DRIVE_W-1:0] drive;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [ERR_W-1:0]    target;
  logic signed [ERR_W-1:0]    feedback;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [DRIVE_W-1:0]  drive;

  logic                       fixed_on;
  logic signed [DRIVE_W-1:0]  fixed_drive;

  logic signed [GAIN_W-1:0]   kp = '0;
  logic signed [GAIN_W-1:0]   ki = '0;
  logic signed [GAIN_W-1:0]   kd = '0;
  logic [DB_W-1:0]            db_level = pid_db_pkg::DEADBAND_RESET;
  logic                       db_on = 1'b1;
  longint                     err_integral = 0;
  longint                     last_err = 0;

  logic signed [DRIVE_W-1:0]  pending_drive [$];
  int unsigned                mismatches = 0;
  int unsigned                cycle_count = 0;
  int unsigned                burst_left = 0;
  bit                         gaps_on = 1'b1;
  bit                         hold_off_req = 1'b0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_CHECKED, 16'sd100, -16'sd100, 32'sd0},
    '{ROW_CHECKED, 16'sh7FFF, 16'sh8000, 32'sd0},
    '{ROW_CHECKED, 16'sh8000, 16'sh7FFF, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_P), 16'h0100, 32'sd0},
    '{ROW_CHECKED, 16'sh7FFF, 16'sh8000, 32'sd32767},
    '{ROW_CHECKED, 16'sh8000, 16'sh7FFF, -32'sd32768},
    '{ROW_CHECKED, 16'sd154, 16'sd0, 32'sd154},
    '{ROW_CHECKED, 16'sd153, 16'sd0, 32'sd0},
    '{ROW_CHECKED, 16'sd0, 16'sd154, -32'sd154},
    '{ROW_CHECKED, 16'sd0, 16'sd153, 32'sd0},
    '{ROW_REG, 16'(REG_UNMAPPED), 16'h0000, 32'sd0},
    '{ROW_CHECKED, 16'sd300, 16'sd0, 32'sd300},
    '{ROW_REG, 16'(pid_db_pkg::REG_DEADBAND_ENABLE), 16'h0000, 32'sd0},
    '{ROW_CHECKED, 16'sd1, 16'sd0, 32'sd1},
    '{ROW_CHECKED, 16'sd0, 16'sd1, -32'sd1},
    '{ROW_CHECKED, 16'sd0, 16'sd0, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_DEADBAND), 16'hFFFF, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_DEADBAND_ENABLE), 16'h0001, 32'sd0},
    '{ROW_CHECKED, 16'sh7FFF, 16'sh8000, 32'sd32767},
    '{ROW_CHECKED, 16'sd32766, 16'sd0, 32'sd0},
    '{ROW_CHECKED, 16'sh8000, 16'sd0, -32'sd32768},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_P), 16'h0000, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_I), 16'h0100, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_D), 16'h0100, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_DEADBAND), 16'h0000, 32'sd0},
    '{ROW_ITEM, 16'sd1000, 16'sd0, 32'sd0},
    '{ROW_ITEM, -16'sd1000, 16'sd24, 32'sd0},
    '{ROW_ITEM, 16'sd0, 16'sd0, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_P), 16'h8000, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_I), 16'h7FFF, 32'sd0},
    '{ROW_REG, 16'(pid_db_pkg::REG_GAIN_D), 16'h8000, 32'sd0},
    '{ROW_ITEM, 16'sh7FFF, 16'sh8000, 32'sd0},
    '{ROW_ITEM, 16'sh8000, 16'sh7FFF, 32'sd0},
    '{ROW_ITEM, 16'sd12345, -16'sd54, 32'sd0}
  };

  pid_controller_with_deadband_top i_dut (
    .clk,
    .rst,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_ready,
    .target,
    .feedback,
    .out_valid,
    .out_ready,
    .drive
  );

  always #10 clk = ~clk;

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      pid_db_pkg::REG_GAIN_P:          kp = data;
      pid_db_pkg::REG_GAIN_I:          ki = data;
      pid_db_pkg::REG_GAIN_D:          kd = data;
      pid_db_pkg::REG_DEADBAND:        db_level = data[DB_W-1:0];
      pid_db_pkg::REG_DEADBAND_ENABLE: db_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [DRIVE_W-1:0] pid_step(logic signed [ERR_W-1:0] tg,
                                                         logic signed [ERR_W-1:0] fb);
    longint err;
    longint mag;
    longint acc;
    longint q;
    err = longint'(tg) - longint'(fb);
    if (err > ERR_HI) err = ERR_HI;
    else if (err < ERR_LO) err = ERR_LO;
    mag = (err < 0) ? -err : err;
    if (db_on && mag < longint'(db_level)) err = 0;
    err_integral = err_integral + err;
    if (err_integral > SUM_HI) err_integral = SUM_HI;
    else if (err_integral < SUM_LO) err_integral = SUM_LO;
    acc = longint'(kp) * err + longint'(ki) * err_integral + longint'(kd) * (err - last_err);
    q = acc >>> FRAC_W;
    if (q > SUM_HI) q = SUM_HI;
    else if (q < SUM_LO) q = SUM_LO;
    last_err = err;
    return q[DRIVE_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    logic signed [DRIVE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        if (mismatches < REPORT_CAP)
          $display("%0t drive: expected none, actual %0d", $time, drive);
        mismatches++;
      end else begin
        want = pending_drive.pop_front();
        if (drive !== want) begin
          if (mismatches < REPORT_CAP)
            $display("%0t drive: expected %0d, actual %0d", $time, want, drive);
          mismatches++;
        end
      end
    end
    if (!rst && cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    if (!rst && in_valid && in_ready) begin
      want = pid_step(target, feedback);
      pending_drive.push_back(fixed_on ? fixed_drive : want);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pid_controller_with_deadband_top: mismatch");
      $finish;
    end
  end

  initial begin : receiver
    stall_mode_t mode;
    int unsigned span;
    out_ready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(4, 40);
        repeat (span) begin
          @(posedge clk);
          case (mode)
            STALL_NONE:  out_ready <= 1'b1;
            STALL_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            STALL_HALF:  out_ready <= ($urandom_range(0, 1) != 0);
            default:     out_ready <= ~out_ready;
          endcase
        end
      end
    end
  end

  task automatic send_item(logic signed [ERR_W-1:0] tg, logic signed [ERR_W-1:0] fb,
                           logic has_drive, logic signed [DRIVE_W-1:0] drv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    target      <= tg;
    feedback    <= fb;
    fixed_on    <= has_drive;
    fixed_drive <= drv;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain: hold input, wait out every pending drive, then the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic sweep(logic signed [ERR_W-1:0] tg, logic signed [ERR_W-1:0] fb,
                       int unsigned count);
    repeat (count) send_item(tg, fb, 1'b0, '0);
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_deadband();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [ERR_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic send_random_item();
    item_kind_t kind;
    logic signed [ERR_W-1:0] tg;
    logic signed [ERR_W-1:0] fb;
    int off;
    kind = item_kind_t'($urandom_range(0, 3));
    fb = 16'($urandom_range(0, 32767)) - 16'sd16384;
    case (kind)
      ITEM_ANY: begin
        tg = 16'($urandom);
        fb = 16'($urandom);
      end
      ITEM_EDGE: begin
        off = int'(db_level) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) != 0) off = -off;
        tg = 16'(int'(fb) + off);
      end
      ITEM_EXTREME: begin
        tg = pick_extreme();
        fb = pick_extreme();
      end
      default: tg = 16'(int'(fb) + int'($urandom_range(0, 128)) - 64);
    endcase
    send_item(tg, fb, 1'b0, '0);
  endtask

  initial begin : stimulus
    dir_row_t row;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    target      <= '0;
    feedback    <= '0;
    fixed_on    <= 1'b0;
    fixed_drive <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = directed_rows[r];
      case (row.kind)
        ROW_REG: begin
          settle();
          write_reg(row.a[IDX_W-1:0], row.b);
        end
        ROW_ITEM:    send_item(row.a, row.b, 1'b0, '0);
        default:     send_item(row.a, row.b, 1'b1, row.drive);
      endcase
    end

    // wind the integral far in both directions, then bring it back
    settle();
    write_reg(pid_db_pkg::REG_GAIN_P, 16'h8000);
    write_reg(pid_db_pkg::REG_GAIN_I, 16'h7FFF);
    write_reg(pid_db_pkg::REG_GAIN_D, 16'h7FFF);
    write_reg(pid_db_pkg::REG_DEADBAND, 16'h0000);
    write_reg(pid_db_pkg::REG_DEADBAND_ENABLE, 16'h0000);
    gaps_on = 1'b0;
    sweep(16'sh8000, 16'sh7FFF, WINDUP_ITEMS);
    sweep(16'sh7FFF, 16'sh8000, 2 * WINDUP_ITEMS);
    sweep(16'sh8000, 16'sh7FFF, RECENTER_ITEMS);
    gaps_on = 1'b1;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_reg(pid_db_pkg::REG_GAIN_P, pick_gain());
      write_reg(pid_db_pkg::REG_GAIN_I, pick_gain());
      write_reg(pid_db_pkg::REG_GAIN_D, pick_gain());
      write_reg(pid_db_pkg::REG_DEADBAND, pick_deadband());
      write_reg(pid_db_pkg::REG_DEADBAND_ENABLE, 16'($urandom));
      if ($urandom_range(0, 1) != 0) write_reg(REG_UNMAPPED, 16'($urandom));
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
    end

    settle();
    if (mismatches == 0)
      $display("pid_controller_with_deadband_top: match");
    else
      $display("pid_controller_with_deadband_top: mismatch");
    $finish;
  end

endmodule
